/* hdl/sfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S.BUS frame serializer package
// Shared types and constants: transaction layouts, op codes, frame geometry.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_W       = 11;
	localparam int FRAME_LENGTH = 25;
	localparam int PACKED_W     = NUM_CHANNELS * CHAN_W;
	localparam int PACKED_BYTES = PACKED_W / 8;

	localparam logic [7:0] HEADER_BYTE   = 8'h0F;
	localparam logic [7:0] END_BYTE      = 8'h00;
	localparam logic [3:0] PARITY_POS    = 4'd9;
	localparam logic [3:0] LAST_BIT_POS  = 4'd11;
	localparam logic [4:0] LAST_BYTE_POS = 5'd24;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_LOAD   = 2'd1,
		OP_COMMIT = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  channel_index;
		logic [10:0] channel_value;
		logic        digital_ch17;
		logic        digital_ch18;
		logic        frame_lost_flag;
		logic        failsafe_flag;
	} cmd_t;

	typedef struct packed {
		logic        wire_level;
		logic        busy_res;
		logic        commit_accepted;
		logic [31:0] frames_sent;
		logic [31:0] frames_dropped;
	} res_t;

	typedef struct packed {
		logic        we;
		logic [3:0]  index;
		logic [10:0] value;
	} stage_wr_t;

	typedef struct packed {
		logic       tick;
		logic       commit;
		logic [3:0] flags;
	} tx_ctl_t;

	typedef struct packed {
		logic        line;
		logic        sending;
		logic        accepted;
		logic [31:0] sent;
		logic [31:0] dropped;
	} tx_status_t;

endpackage

/* hdl/sfs_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface sfs_cmd_if;
	logic          valid;
	logic          ready;
	sfs_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sfs_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface sfs_res_if;
	logic          valid;
	logic          ready;
	sfs_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sbus_frame_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S.BUS frame serializer
// Stages channel words, packs a 25-byte frame on commit, sends it as 8E2.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries tick, channel-load and commit transactions; res returns
//   exactly one result transaction per command, in order.
//   cfg_we/cfg_data write invert_line; write it only while the block is idle.
//   A command accepted on cmd is held in the input register, processed when
//   it can move on, and its result is then registered in the result register.
//   Throughput is one command per cycle: the input register and the result
//   register both advance every cycle while res is taken.
//   Each tick command sends one line bit; a frame takes 25 x 12 ticks.
//   If res stalls, the held result keeps its value, one further command is
//   taken into the input register, and cmd.ready then drops.
//   After reset: staging store zero, line at mark, not sending, counters
//   zero, invert_line clear.
// ----------------------------------------------------------------------------
module sbus_frame_serializer (
	input  logic            clk,
	input  logic            arst_n,
	sfs_cmd_if.sink         cmd,
	sfs_res_if.source       res,
	input  logic            cfg_we,
	input  logic            cfg_data
);

	logic                          valid_s1;
	sfs_pkg::cmd_t                 item_s1;
	logic                          advance;
	logic                          invert_q;
	logic                          res_valid_q;
	sfs_pkg::res_t                 res_q;
	sfs_pkg::stage_wr_t            stage_wr;
	sfs_pkg::tx_ctl_t              tx_ctl;
	sfs_pkg::tx_status_t           tx_status;
	logic [sfs_pkg::PACKED_W-1:0]  packed_chans;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_we) begin
			invert_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	assign stage_wr.we    = advance && (item_s1.op == sfs_pkg::OP_LOAD);
	assign stage_wr.index = item_s1.channel_index;
	assign stage_wr.value = item_s1.channel_value;

	assign tx_ctl.tick   = advance && (item_s1.op == sfs_pkg::OP_TICK);
	assign tx_ctl.commit = advance && (item_s1.op == sfs_pkg::OP_COMMIT);
	assign tx_ctl.flags  = {item_s1.failsafe_flag, item_s1.frame_lost_flag,
		item_s1.digital_ch18, item_s1.digital_ch17};

	sfs_staging u_staging (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (stage_wr),
		.packed_chans (packed_chans)
	);

	sfs_frame_tx u_frame_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (tx_ctl),
		.packed_chans (packed_chans),
		.status       (tx_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.wire_level      <= tx_status.line ^ invert_q;
			res_q.busy_res        <= tx_status.sending;
			res_q.commit_accepted <= tx_status.accepted;
			res_q.frames_sent     <= tx_status.sent;
			res_q.frames_dropped  <= tx_status.dropped;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

/* hdl/sfs_staging.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel staging store
// Sixteen 11-bit channel words, presented as one LSB-first packed vector.
// ----------------------------------------------------------------------------
module sfs_staging (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfs_pkg::stage_wr_t              wr,
	output logic [sfs_pkg::PACKED_W-1:0]    packed_chans
);

	logic [sfs_pkg::CHAN_W-1:0] chan_q [sfs_pkg::NUM_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfs_pkg::NUM_CHANNELS; i++) begin
				chan_q[i] <= '0;
			end
		end else if (wr.we) begin
			chan_q[wr.index] <= wr.value;
		end
	end

	for (genvar g = 0; g < sfs_pkg::NUM_CHANNELS; g++) begin : g_pack
		assign packed_chans[g*sfs_pkg::CHAN_W +: sfs_pkg::CHAN_W] = chan_q[g];
	end

endmodule

/* hdl/sfs_frame_tx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer and 8E2 bit sender
// Latches a packed frame on a commit while idle and emits one UART bit per tick.
// ----------------------------------------------------------------------------
module sfs_frame_tx (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfs_pkg::tx_ctl_t                ctl,
	input  logic [sfs_pkg::PACKED_W-1:0]    packed_chans,
	output sfs_pkg::tx_status_t             status
);

	logic [7:0]  frame_q [sfs_pkg::FRAME_LENGTH];
	logic [4:0]  byte_pos_q, byte_pos_d;
	logic [3:0]  bit_pos_q, bit_pos_d;
	logic        sending_q, sending_d;
	logic        line_q, line_d;
	logic [31:0] sent_q, sent_d;
	logic [31:0] dropped_q, dropped_d;
	logic        accepted;
	logic [7:0]  cur_byte;
	logic [3:0]  data_idx;
	logic        bit_val;
	logic        take;

	assign take     = ctl.commit && !sending_q;
	assign cur_byte = frame_q[byte_pos_q];
	assign data_idx = bit_pos_q - 4'd1;

	always_comb begin
		if (bit_pos_q == 4'd0) begin
			bit_val = 1'b0;
		end else if (bit_pos_q < sfs_pkg::PARITY_POS) begin
			bit_val = cur_byte[data_idx[2:0]];
		end else if (bit_pos_q == sfs_pkg::PARITY_POS) begin
			bit_val = ^cur_byte;
		end else begin
			bit_val = 1'b1;
		end
	end

	always_comb begin
		byte_pos_d = byte_pos_q;
		bit_pos_d  = bit_pos_q;
		sending_d  = sending_q;
		line_d     = line_q;
		sent_d     = sent_q;
		dropped_d  = dropped_q;
		accepted   = 1'b0;
		if (ctl.tick) begin
			if (!sending_q) begin
				line_d = 1'b1;
			end else begin
				line_d = bit_val;
				if (bit_pos_q == sfs_pkg::LAST_BIT_POS) begin
					bit_pos_d = '0;
					if (byte_pos_q == sfs_pkg::LAST_BYTE_POS) begin
						byte_pos_d = '0;
						sending_d  = 1'b0;
						sent_d     = sent_q + 32'd1;
						line_d     = 1'b1;
					end else begin
						byte_pos_d = byte_pos_q + 5'd1;
					end
				end else begin
					bit_pos_d = bit_pos_q + 4'd1;
				end
			end
		end else if (ctl.commit) begin
			if (sending_q) begin
				dropped_d = dropped_q + 32'd1;
			end else begin
				byte_pos_d = '0;
				bit_pos_d  = '0;
				sending_d  = 1'b1;
				accepted   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			bit_pos_q  <= '0;
			sending_q  <= 1'b0;
			line_q     <= 1'b1;
			sent_q     <= '0;
			dropped_q  <= '0;
		end else begin
			byte_pos_q <= byte_pos_d;
			bit_pos_q  <= bit_pos_d;
			sending_q  <= sending_d;
			line_q     <= line_d;
			sent_q     <= sent_d;
			dropped_q  <= dropped_d;
		end
	end

	// frame buffer, no reset: only read after a commit fills it
	always_ff @(posedge clk) begin
		if (take) begin
			frame_q[0] <= sfs_pkg::HEADER_BYTE;
			for (int k = 0; k < sfs_pkg::PACKED_BYTES; k++) begin
				frame_q[k+1] <= packed_chans[k*8 +: 8];
			end
			frame_q[sfs_pkg::FRAME_LENGTH-2] <= {4'd0, ctl.flags};
			frame_q[sfs_pkg::FRAME_LENGTH-1] <= sfs_pkg::END_BYTE;
		end
	end

	assign status.line     = line_d;
	assign status.sending  = sending_d;
	assign status.accepted = accepted;
	assign status.sent     = sent_d;
	assign status.dropped  = dropped_d;

	a_idle_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (bit_pos_q == 4'd0 && byte_pos_q == 5'd0))
		else $error("position counters not cleared while idle");

	a_idle_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> line_q)
		else $error("line not at mark while idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= sfs_pkg::LAST_BIT_POS)
		else $error("bit position out of range");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= sfs_pkg::LAST_BYTE_POS)
		else $error("byte position out of range");

	a_sent_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sending_q) |-> sent_q == $past(sent_q) + 32'd1)
		else $error("frame end not counted");

endmodule
